>>> rtl/core/mwwa_pkg.sv
// mwwa_pkg: shared constants, widths and types of the masked window weighted average unit
// no dependencies; imported by masked_window_weighted_average_unit
package mwwa_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int MAX_RADIUS = 16;
	localparam int ELEMS      = 16;

	localparam int FRAME_W = $clog2(MAX_FRAMES);
	localparam int ELEM_W  = $clog2(ELEMS);
	localparam int ADDR_W  = FRAME_W + ELEM_W;
	localparam int DEPTH   = MAX_FRAMES * ELEMS;

	// field and register widths
	localparam int VALUE_W  = 32;
	localparam int ALPHA_W  = 17;
	localparam int RADIUS_W = 5;
	localparam int FCNT_W   = 7;
	localparam int CFG_IDX_W = 2;

	// arithmetic widths: weight 0..65536, numerator up to 33 * 2^31 * 2^16
	localparam int WGT_W  = 17;
	localparam int PROD_W = 51;
	localparam int NUM_W  = 55;
	localparam int DEN_W  = 22;
	localparam int QUO_W  = NUM_W - DEN_W;
	localparam int CNT_W  = 6;

	localparam logic [WGT_W-1:0]    ONE_Q16   = 17'd65536;
	localparam logic [RADIUS_W-1:0] RADIUS_MAX = 5'd16;
	localparam logic [FCNT_W-1:0]   FCNT_MAX  = 7'd64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd2;

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_MOD  = 12'b0000_0000_0010,
		ST_RD   = 12'b0000_0000_0100,
		ST_MUL  = 12'b0000_0000_1000,
		ST_ACC  = 12'b0000_0001_0000,
		ST_WMUL = 12'b0000_0010_0000,
		ST_WRND = 12'b0000_0100_0000,
		ST_PREP = 12'b0000_1000_0000,
		ST_CHK  = 12'b0001_0000_0000,
		ST_DIV  = 12'b0010_0000_0000,
		ST_FIN  = 12'b0100_0000_0000,
		ST_OUT  = 12'b1000_0000_0000
	} state_t;

endpackage

>>> rtl/core/masked_window_weighted_average_unit.sv
// masked_window_weighted_average_unit: frame store with decaying-weight window average
// depends on mwwa_pkg
// a write is stored in the idle state as it is accepted; a query walks each window position
// once through the single shared multiplier, then runs a 33-step restoring divider unless
// no frame is valid or the quotient saturates; one item is in work at a time
// reset clears the valid flags, the configuration (alpha 0.5, radius 2, 64 frames) and the
// output valid flag; the element store holds no reset value and needs no clearing pass
module masked_window_weighted_average_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mwwa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mwwa_pkg::ALPHA_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [mwwa_pkg::FRAME_W-1:0]      frame_index,
	input  logic [mwwa_pkg::ELEM_W-1:0]       element_index,
	input  logic signed [mwwa_pkg::VALUE_W-1:0] element_value,
	input  logic                              frame_valid,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mwwa_pkg::VALUE_W-1:0] smoothed_value,
	output logic                              no_valid_frames
);
	import mwwa_pkg::*;

	state_t state_q;

	// configuration
	logic [ALPHA_W-1:0]  decay_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [FCNT_W-1:0]   fcnt_q;
	logic [ALPHA_W-1:0]  alpha;
	logic [RADIUS_W-1:0] r_eff;
	logic [FCNT_W-1:0]   fc_eff;
	logic [FCNT_W-1:0]   fc_last;

	// store
	logic [VALUE_W-1:0]    mem [DEPTH];
	logic [MAX_FRAMES-1:0] valid_q;
	logic [VALUE_W-1:0]    rdata_q;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  wr_en;

	// walk state
	logic [ELEM_W-1:0]   elem_q;
	logic [FRAME_W-1:0]  modr_q;
	logic [FRAME_W-1:0]  modr_nx;
	logic [FRAME_W+FCNT_W-2:0] dv_q;
	logic [FRAME_W-1:0]  pm_q;
	logic [FRAME_W-1:0]  pp_q;
	logic [FRAME_W-1:0]  pm_nx;
	logic [FRAME_W-1:0]  pp_nx;
	logic [FRAME_W-1:0]  idx;
	logic                side_q;
	logic [RADIUS_W-1:0] d_q;
	logic [WGT_W-1:0]    w_q;
	logic                vld_q;
	logic [CNT_W-1:0]    cnt_q;

	// shared multiplier
	logic signed [VALUE_W:0]  mul_a;
	logic signed [WGT_W:0]    mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] prod_q;
	logic [34:0]              wr_sum;

	// accumulation and division
	logic signed [NUM_W-1:0] num_q;
	logic [DEN_W-1:0]        den_q;
	logic [NUM_W-1:0]        mag;
	logic [NUM_W-1:0]        div_q;
	logic                    neg_q;
	logic [DEN_W-1:0]        rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic [DEN_W:0]          trial;
	logic                    ge;
	logic [DEN_W:0]          trial_sub;
	logic [QUO_W-1:0]        quo_neg;
	logic [VALUE_W-1:0]      fin_val;

	logic [VALUE_W-1:0] res_q;
	logic               nvf_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_val_q;
	logic               out_nvf_q;

	assign cfg_ready       = 1'b1;
	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign smoothed_value  = out_val_q;
	assign no_valid_frames = out_nvf_q;

	always_comb begin
		alpha   = (decay_q > ONE_Q16) ? ONE_Q16 : decay_q;
		r_eff   = (radius_q > RADIUS_MAX) ? RADIUS_MAX : radius_q;
		fc_eff  = (fcnt_q == '0) ? 7'd1 : ((fcnt_q > FCNT_MAX) ? FCNT_MAX : fcnt_q);
		fc_last = fc_eff - 7'd1;
		idx     = side_q ? pp_q : pm_q;
		rd_addr = {idx, elem_q};
		wr_en   = (state_q == ST_IDLE) && in_valid && (req_type == REQ_WRITE);
		// one step of the center modulo
		modr_nx = modr_q;
		if ({6'b0, modr_q} >= dv_q) begin
			modr_nx = modr_q - dv_q[FRAME_W-1:0];
		end
		pm_nx = (pm_q == '0) ? fc_last[FRAME_W-1:0] : (pm_q - 6'd1);
		pp_nx = ({1'b0, pp_q} == fc_last) ? '0 : (pp_q + 6'd1);
	end

	// one multiplier serves the weight decay and the weighted element
	always_comb begin
		if (state_q == ST_WMUL) begin
			mul_a = signed'({16'b0, w_q});
			mul_b = signed'({1'b0, alpha});
		end else begin
			mul_a = signed'({rdata_q[VALUE_W-1], rdata_q});
			mul_b = signed'({1'b0, w_q});
		end
		mul_p  = mul_a * mul_b;
		wr_sum = {1'b0, prod_q[33:0]} + 35'd32768;
	end

	always_comb begin
		mag       = num_q[NUM_W-1] ? (~num_q + 55'd1) : num_q;
		trial     = {rem_q, quo_q[QUO_W-1]};
		ge        = (trial >= {1'b0, den_q});
		trial_sub = trial - {1'b0, den_q};
		quo_neg   = ~quo_q + 33'd1;
		if (neg_q) begin
			fin_val = (quo_q > 33'h0_8000_0000) ? 32'h8000_0000 : quo_neg[VALUE_W-1:0];
		end else begin
			fin_val = (quo_q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quo_q[VALUE_W-1:0];
		end
	end

	// element store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{frame_index, element_index}] <= element_value;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q  <= 17'd32768;
			radius_q <= 5'd2;
			fcnt_q   <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DECAY:  decay_q  <= cfg_data;
				CFG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				CFG_FRAMES: fcnt_q   <= cfg_data[FCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[frame_index] <= frame_valid;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			side_q  <= 1'b0;
			d_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && req_type == REQ_QUERY) begin
						cnt_q   <= 6'd5;
						side_q  <= 1'b0;
						d_q     <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= ST_RD;
					end
				end
				ST_RD:   state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ACC;
				ST_ACC: begin
					if (d_q != '0 && !side_q) begin
						side_q  <= 1'b1;
						state_q <= ST_RD;
					end else if (d_q == r_eff) begin
						state_q <= ST_PREP;
					end else begin
						side_q  <= 1'b0;
						d_q     <= d_q + 5'd1;
						state_q <= ST_WMUL;
					end
				end
				ST_WMUL: state_q <= ST_WRND;
				ST_WRND: state_q <= ST_RD;
				ST_PREP: state_q <= ST_CHK;
				ST_CHK: begin
					if (den_q == '0 || div_q[NUM_W-1:QUO_W] >= den_q) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q   <= 6'(QUO_W);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN:  state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				elem_q <= element_index;
				modr_q <= frame_index;
				dv_q   <= {fc_eff, 5'b0};
				w_q    <= ONE_Q16;
				num_q  <= '0;
				den_q  <= '0;
			end
			ST_MOD: begin
				modr_q <= modr_nx;
				dv_q   <= dv_q >> 1;
				pm_q   <= modr_nx;
				pp_q   <= modr_nx;
			end
			ST_RD: vld_q <= valid_q[idx];
			ST_MUL, ST_WMUL: prod_q <= mul_p;
			ST_ACC: begin
				if (vld_q) begin
					num_q <= num_q + {{(NUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
					den_q <= den_q + {5'b0, w_q};
				end
				// pointers move out one frame on each side once both sides are done
				if (d_q == '0 || side_q) begin
					pm_q <= pm_nx;
					pp_q <= pp_nx;
				end
			end
			ST_WRND: w_q <= wr_sum[32:16];
			ST_PREP: begin
				div_q <= mag + {34'b0, den_q[DEN_W-1:1]};
				neg_q <= num_q[NUM_W-1];
			end
			ST_CHK: begin
				rem_q <= div_q[NUM_W-1:QUO_W];
				quo_q <= div_q[QUO_W-1:0];
				if (den_q == '0) begin
					res_q <= '0;
					nvf_q <= 1'b1;
				end else begin
					// quotient of 2^33 or more always saturates
					res_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
					nvf_q <= 1'b0;
				end
			end
			ST_DIV: begin
				rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], ge};
			end
			ST_FIN: begin
				res_q <= fin_val;
				nvf_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_val_q <= res_q;
			out_nvf_q <= nvf_q;
		end
	end

endmodule
